@@ rtl/c_token_scanner_assert.svh @@
// ----------------------------------------------------------------------------
// c_token_scanner_assert: assertion macros used by the scanner queue
// clock clk, synchronous active-low reset rst_n
// ----------------------------------------------------------------------------
`ifndef C_TOKEN_SCANNER_ASSERT_SVH
`define C_TOKEN_SCANNER_ASSERT_SVH

// property that must hold at every edge out of reset
`define CTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cause in one cycle, effect in the next
`define CTS_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error(msg);

`endif

@@ rtl/cts_pkg.sv @@
// ----------------------------------------------------------------------------
// cts_pkg
// types, codes and symbol tables of the c token scanner
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int POS_W       = 16;
  localparam int MAX_OUT     = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int OP_COUNT    = 34;
  localparam int PUNCT_COUNT = 13;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // token classes
  localparam logic [2:0] CLS_ERROR   = 3'd0;
  localparam logic [2:0] CLS_LITERAL = 3'd1;
  localparam logic [2:0] CLS_OP      = 3'd2;
  localparam logic [2:0] CLS_PUNCT   = 3'd3;
  localparam logic [2:0] CLS_EOF     = 3'd4;

  // codes
  localparam logic [5:0] ERR_BADCHAR = 6'd0;
  localparam logic [5:0] ERR_PREFIX  = 6'd1;
  localparam logic [1:0] RADIX_DEC   = 2'd0;
  localparam logic [1:0] RADIX_HEX   = 2'd1;
  localparam logic [1:0] RADIX_BIN   = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_ZERO, MODE_DEC, MODE_PREFIX, MODE_DIGITS, MODE_SYMBOL
  } mode_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       token_class;
    logic [5:0]       token_code;
    logic [63:0]      literal_value;
    logic             literal_overflow;
    logic [POS_W-1:0] token_line;
    logic [POS_W-1:0] token_column;
    logic             last_of_run;
  } tok_t;

  // all results of one input item
  typedef struct packed {
    tok_t [MAX_OUT-1:0] toks;
    logic [2:0]         cnt;
  } bundle_t;

  typedef struct packed {
    logic [1:0] len;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
  } sym_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] cls;
    logic [5:0] code;
  } match_t;

  localparam logic [7:0] NUL = 8'h00;

  localparam sym_t OP_TAB [OP_COUNT] = '{
    '{2'd1, "<", NUL, NUL}, '{2'd1, ">", NUL, NUL}, '{2'd1, "*", NUL, NUL},
    '{2'd1, "&", NUL, NUL}, '{2'd1, "+", NUL, NUL}, '{2'd1, "-", NUL, NUL},
    '{2'd1, "/", NUL, NUL}, '{2'd1, "%", NUL, NUL}, '{2'd2, "=", "=", NUL},
    '{2'd2, "!", "=", NUL}, '{2'd2, ">", "=", NUL}, '{2'd2, "<", "=", NUL},
    '{2'd2, "&", "&", NUL}, '{2'd2, "|", "|", NUL}, '{2'd1, "!", NUL, NUL},
    '{2'd1, "|", NUL, NUL}, '{2'd1, "^", NUL, NUL}, '{2'd1, "~", NUL, NUL},
    '{2'd2, "<", "<", NUL}, '{2'd2, ">", ">", NUL}, '{2'd1, "=", NUL, NUL},
    '{2'd2, "+", "=", NUL}, '{2'd2, "-", "=", NUL}, '{2'd2, "*", "=", NUL},
    '{2'd2, "/", "=", NUL}, '{2'd2, "%", "=", NUL}, '{2'd2, "&", "=", NUL},
    '{2'd2, "|", "=", NUL}, '{2'd2, "^", "=", NUL}, '{2'd3, "<", "<", "="},
    '{2'd3, ">", ">", "="}, '{2'd2, "+", "+", NUL}, '{2'd2, "-", "-", NUL},
    '{2'd1, "?", NUL, NUL}
  };

  localparam sym_t PUNCT_TAB [PUNCT_COUNT] = '{
    '{2'd1, "{", NUL, NUL}, '{2'd1, "}", NUL, NUL}, '{2'd1, "[", NUL, NUL},
    '{2'd1, "]", NUL, NUL}, '{2'd1, "(", NUL, NUL}, '{2'd1, ")", NUL, NUL},
    '{2'd1, ",", NUL, NUL}, '{2'd1, ";", NUL, NUL}, '{2'd1, ":", NUL, NUL},
    '{2'd2, ":", ":", NUL}, '{2'd1, ".", NUL, NUL}, '{2'd3, ".", ".", "."},
    '{2'd2, "-", ">", NUL}
  };

  function automatic logic sym_eq(sym_t e, logic [7:0] w0, logic [7:0] w1,
                                  logic [7:0] w2, logic [1:0] n);
    return (e.len == n) && (e.c0 == w0) && (n < 2'd2 || e.c1 == w1) &&
           (n < 2'd3 || e.c2 == w2);
  endfunction

  function automatic logic sym_ext(sym_t e, logic [7:0] w0, logic [7:0] w1,
                                   logic [7:0] w2, logic [1:0] n);
    return (e.len > n) && (n < 2'd1 || e.c0 == w0) && (n < 2'd2 || e.c1 == w1) &&
           (n < 2'd3 || e.c2 == w2);
  endfunction

  // exact match, lowest operator index first, then punctuation
  function automatic match_t find_exact(logic [7:0] w0, logic [7:0] w1,
                                        logic [7:0] w2, logic [1:0] n);
    match_t m;
    m = '0;
    for (int i = PUNCT_COUNT - 1; i >= 0; i--) begin
      if (sym_eq(PUNCT_TAB[i], w0, w1, w2, n)) begin
        m = '{1'b1, CLS_PUNCT, 6'(i)};
      end
    end
    for (int i = OP_COUNT - 1; i >= 0; i--) begin
      if (sym_eq(OP_TAB[i], w0, w1, w2, n)) begin
        m = '{1'b1, CLS_OP, 6'(i)};
      end
    end
    return m;
  endfunction

  function automatic logic can_ext(logic [7:0] w0, logic [7:0] w1,
                                   logic [7:0] w2, logic [1:0] n);
    logic r;
    r = 1'b0;
    for (int i = 0; i < OP_COUNT; i++) r = r | sym_ext(OP_TAB[i], w0, w1, w2, n);
    for (int i = 0; i < PUNCT_COUNT; i++) r = r | sym_ext(PUNCT_TAB[i], w0, w1, w2, n);
    return r;
  endfunction

  function automatic logic [POS_W-1:0] pos_add(logic [POS_W-1:0] p, logic [1:0] k);
    logic [POS_W:0] s;
    s = {1'b0, p} + {{(POS_W-1){1'b0}}, k};
    return s[POS_W] ? POS_MAX : s[POS_W-1:0];
  endfunction

  function automatic tok_t mk_tok(logic [2:0] cls, logic [5:0] code, logic [63:0] val,
                                  logic ovf, logic [POS_W-1:0] ln,
                                  logic [POS_W-1:0] col);
    tok_t t;
    t.token_class      = cls;
    t.token_code       = code;
    t.literal_value    = val;
    t.literal_overflow = ovf;
    t.token_line       = ln;
    t.token_column     = col;
    t.last_of_run      = 1'b0;
    return t;
  endfunction

endpackage

@@ rtl/cts_front.sv @@
// ----------------------------------------------------------------------------
// cts_front
// takes one byte a cycle on take, classifies it, builds the tokens it closes
// ----------------------------------------------------------------------------
module cts_front
  import cts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  in_item_t item,
  output logic     bundle_push,
  output bundle_t  bundle
);

  logic [POS_W-1:0] ln_r, ln_nxt, col_r, col_nxt, sl_r, sl_nxt, sc_r, sc_nxt;
  logic [7:0]       w_r [3];
  logic [7:0]       w_nxt [3];
  logic [1:0]       fill_r, fill_nxt;
  mode_t            mode_r, mode_nxt;
  logic [1:0]       radix_r, radix_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic             ovf_r, ovf_nxt, halt_r, halt_nxt;

  logic [7:0]  c;
  logic [3:0]  dv;
  logic        dok, is_dig, is_sp, is_sym;
  logic [67:0] prod;
  logic [63:0] acc_new;
  logic        ovf_new;
  tok_t        toks [MAX_OUT];
  logic [2:0]  cnt;
  logic        do_push, do_flush, beg, b_dig, b_sym, b_bad;
  match_t      m1, m2, m3, m;
  logic [1:0]  len;
  match_t      ms;

  // byte classification, digit decode and literal accumulate
  always_comb begin
    c      = item.byte_in;
    is_dig = (c >= "0" && c <= "9");
    is_sp  = (c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0b ||
              c == 8'h0c || c == 8'h0d);
    ms     = find_exact(c, NUL, NUL, 2'd1);
    is_sym = ms.hit;
    dok    = 1'b1;
    dv     = 4'd0;
    if (is_dig) dv = 4'(c - "0");
    else if (c >= "a" && c <= "f") dv = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") dv = 4'(c - "A" + 8'd10);
    else dok = 1'b0;
    if (radix_r == RADIX_DEC && dv > 4'd9) dok = 1'b0;
    if (radix_r == RADIX_BIN && dv > 4'd1) dok = 1'b0;
    if (radix_r == RADIX_HEX)      prod = {acc_r, 4'd0} + {64'd0, dv};
    else if (radix_r == RADIX_BIN) prod = {3'd0, acc_r, 1'b0} + {64'd0, dv};
    else prod = {1'b0, acc_r, 3'd0} + {3'd0, acc_r, 1'b0} + {64'd0, dv};
    if (ovf_r) begin
      acc_new = acc_r;
      ovf_new = 1'b1;
    end else if (prod[67:64] != 4'd0) begin
      acc_new = '1;
      ovf_new = 1'b1;
    end else begin
      acc_new = prod[63:0];
      ovf_new = 1'b0;
    end
  end

  // scanner step
  always_comb begin
    ln_nxt = ln_r; col_nxt = col_r; sl_nxt = sl_r; sc_nxt = sc_r;
    w_nxt = w_r; fill_nxt = fill_r; mode_nxt = mode_r; radix_nxt = radix_r;
    acc_nxt = acc_r; ovf_nxt = ovf_r; halt_nxt = halt_r;
    for (int i = 0; i < MAX_OUT; i++) toks[i] = '0;
    cnt = 3'd0;
    do_push = 1'b0; do_flush = 1'b0; beg = 1'b0;
    b_dig = 1'b0; b_sym = 1'b0; b_bad = 1'b0;
    m1 = '0; m2 = '0; m3 = '0; m = '0; len = 2'd1;

    if (take) begin
      if (item.end_of_input) begin
        // flush what is pending
        if (!halt_r) begin
          case (mode_r)
            MODE_ZERO, MODE_DEC, MODE_DIGITS: begin
              toks[cnt[1:0]] = mk_tok(CLS_LITERAL, {4'd0, radix_r}, acc_r, ovf_r,
                                      sl_r, sc_r);
              cnt = cnt + 3'd1;
            end
            MODE_PREFIX: begin
              toks[cnt[1:0]] = mk_tok(CLS_ERROR, ERR_PREFIX, 64'd0, 1'b0, sl_r, sc_r);
              cnt = cnt + 3'd1;
            end
            MODE_SYMBOL: do_flush = 1'b1;
            default: ;
          endcase
        end
      end else if (!halt_r) begin
        // per-mode handling of the byte
        unique case (mode_r)
          MODE_ZERO: begin
            if (c == "x" || c == "X") begin
              radix_nxt = RADIX_HEX; mode_nxt = MODE_PREFIX;
            end else if (c == "b" || c == "B") begin
              radix_nxt = RADIX_BIN; mode_nxt = MODE_PREFIX;
            end else if (is_dig) begin
              acc_nxt = acc_new; ovf_nxt = ovf_new; mode_nxt = MODE_DEC;
            end else begin
              toks[cnt[1:0]] = mk_tok(CLS_LITERAL, {4'd0, radix_r}, acc_r, ovf_r,
                                      sl_r, sc_r);
              cnt = cnt + 3'd1;
              mode_nxt = MODE_IDLE; beg = 1'b1;
            end
          end
          MODE_PREFIX: begin
            if (dok) begin
              acc_nxt = acc_new; ovf_nxt = ovf_new; mode_nxt = MODE_DIGITS;
            end else begin
              toks[cnt[1:0]] = mk_tok(CLS_ERROR, ERR_PREFIX, 64'd0, 1'b0, sl_r, sc_r);
              cnt = cnt + 3'd1;
              mode_nxt = MODE_IDLE; halt_nxt = 1'b1;
            end
          end
          MODE_DEC, MODE_DIGITS: begin
            if (dok) begin
              acc_nxt = acc_new; ovf_nxt = ovf_new;
            end else begin
              toks[cnt[1:0]] = mk_tok(CLS_LITERAL, {4'd0, radix_r}, acc_r, ovf_r,
                                      sl_r, sc_r);
              cnt = cnt + 3'd1;
              mode_nxt = MODE_IDLE; beg = 1'b1;
            end
          end
          MODE_SYMBOL: begin
            if (is_sym) begin
              do_push = 1'b1;
            end else begin
              do_flush = 1'b1; mode_nxt = MODE_IDLE; beg = 1'b1;
            end
          end
          default: begin
            mode_nxt = MODE_IDLE; beg = 1'b1;
          end
        endcase

        // start of a new token
        if (beg && !is_sp) begin
          if (is_dig) b_dig = 1'b1;
          else if (is_sym) b_sym = 1'b1;
          else b_bad = 1'b1;
        end
        if (b_sym) do_push = 1'b1;

        // shift the byte into the symbol window
        if (do_push) begin
          if (fill_nxt == 2'd0) begin
            sl_nxt = ln_r; sc_nxt = col_r;
          end
          w_nxt[fill_nxt] = c;
          fill_nxt = fill_nxt + 2'd1;
        end
      end

      // longest match at the window head, up to three heads
      for (int k = 0; k < 3; k++) begin
        if (fill_nxt != 2'd0 &&
            (do_flush || !can_ext(w_nxt[0], w_nxt[1], w_nxt[2], fill_nxt))) begin
          m3 = find_exact(w_nxt[0], w_nxt[1], w_nxt[2], 2'd3);
          m2 = find_exact(w_nxt[0], w_nxt[1], w_nxt[2], 2'd2);
          m1 = find_exact(w_nxt[0], w_nxt[1], w_nxt[2], 2'd1);
          if (fill_nxt == 2'd3 && m3.hit) begin
            len = 2'd3; m = m3;
          end else if (fill_nxt >= 2'd2 && m2.hit) begin
            len = 2'd2; m = m2;
          end else begin
            len = 2'd1; m = m1;
          end
          if (!m.hit) begin
            m.cls = CLS_ERROR; m.code = ERR_BADCHAR;
          end
          if (cnt < 3'(MAX_OUT)) begin
            toks[cnt[1:0]] = mk_tok(m.cls, m.code, 64'd0, 1'b0, sl_nxt, sc_nxt);
            cnt = cnt + 3'd1;
          end
          if (len == 2'd1) begin
            w_nxt[0] = w_nxt[1]; w_nxt[1] = w_nxt[2]; w_nxt[2] = NUL;
          end else if (len == 2'd2) begin
            w_nxt[0] = w_nxt[2]; w_nxt[1] = NUL; w_nxt[2] = NUL;
          end else begin
            w_nxt[0] = NUL; w_nxt[1] = NUL; w_nxt[2] = NUL;
          end
          fill_nxt = fill_nxt - len;
          sc_nxt   = pos_add(sc_nxt, len);
        end
      end
      if (do_push) mode_nxt = (fill_nxt != 2'd0) ? MODE_SYMBOL : MODE_IDLE;
      if (do_flush) mode_nxt = MODE_IDLE;

      // literal start, after the flush so the old start position is used
      if (b_dig) begin
        sl_nxt = ln_r; sc_nxt = col_r;
        radix_nxt = RADIX_DEC; ovf_nxt = 1'b0;
        acc_nxt = {60'd0, 4'(c - "0")};
        mode_nxt = (c == "0") ? MODE_ZERO : MODE_DEC;
      end
      if (b_bad && cnt < 3'(MAX_OUT)) begin
        toks[cnt[1:0]] = mk_tok(CLS_ERROR, ERR_BADCHAR, 64'd0, 1'b0, ln_r, col_r);
        cnt = cnt + 3'd1;
        halt_nxt = 1'b1;
      end

      if (item.end_of_input) begin
        // end token, then back to the reset state
        if (cnt < 3'(MAX_OUT)) begin
          toks[cnt[1:0]] = mk_tok(CLS_EOF, 6'd0, 64'd0, 1'b0, ln_r, col_r);
          cnt = cnt + 3'd1;
        end
        ln_nxt = POS_W'(1); col_nxt = POS_W'(1); sl_nxt = POS_W'(1); sc_nxt = POS_W'(1);
        w_nxt[0] = NUL; w_nxt[1] = NUL; w_nxt[2] = NUL;
        fill_nxt = 2'd0; mode_nxt = MODE_IDLE; radix_nxt = RADIX_DEC;
        acc_nxt = 64'd0; ovf_nxt = 1'b0; halt_nxt = 1'b0;
      end else if (c == 8'h0a) begin
        ln_nxt = pos_add(ln_r, 2'd1); col_nxt = POS_W'(1);
      end else begin
        col_nxt = pos_add(col_r, 2'd1);
      end

      if (cnt != 3'd0) toks[2'(cnt - 3'd1)].last_of_run = 1'b1;
    end
  end

  // pack the results for the queue
  always_comb begin
    for (int i = 0; i < MAX_OUT; i++) bundle.toks[i] = toks[i];
    bundle.cnt  = cnt;
    bundle_push = take && (cnt != 3'd0);
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ln_r <= POS_W'(1); col_r <= POS_W'(1); sl_r <= POS_W'(1); sc_r <= POS_W'(1);
      w_r[0] <= NUL; w_r[1] <= NUL; w_r[2] <= NUL;
      fill_r <= 2'd0; mode_r <= MODE_IDLE; radix_r <= RADIX_DEC;
      acc_r <= 64'd0; ovf_r <= 1'b0; halt_r <= 1'b0;
    end else begin
      ln_r <= ln_nxt; col_r <= col_nxt; sl_r <= sl_nxt; sc_r <= sc_nxt;
      w_r <= w_nxt; fill_r <= fill_nxt; mode_r <= mode_nxt; radix_r <= radix_nxt;
      acc_r <= acc_nxt; ovf_r <= ovf_nxt; halt_r <= halt_nxt;
    end
  end

endmodule

@@ rtl/cts_queue.sv @@
// ----------------------------------------------------------------------------
// cts_queue
// short queue of result bundles between the front and the back
// ----------------------------------------------------------------------------
module cts_queue
  import cts_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_i,
  input  bundle_t wdata,
  input  logic    pop_i,
  output bundle_t head,
  output logic    full,
  output logic    empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem [DEPTH];
  logic [PTR_W-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  // pointer and count update
  always_comb begin
    do_wr   = push_i && !full;
    do_rd   = pop_i && !empty;
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (do_rd) rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

`include "c_token_scanner_assert.svh"

  `CTS_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(DEPTH), "queue count over depth")
  `CTS_ASSERT(a_no_push_full, full |-> !push_i, "front pushed into a full queue")
  `CTS_ASSERT(a_head_nonzero, !empty |-> head.cnt != 3'd0, "queued bundle holds no item")
  `CTS_ASSERT_NEXT(a_cnt_up, push_i && !pop_i && !full, cnt_r == $past(cnt_r) + 1'b1, "queue count did not grow")

endmodule

@@ rtl/cts_back.sv @@
// ----------------------------------------------------------------------------
// cts_back
// hands out the tokens of the head bundle one per pop
// ----------------------------------------------------------------------------
module cts_back
  import cts_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  bundle_t head,
  input  logic    q_empty,
  output logic    q_pop,
  output tok_t    out_item,
  input  logic    pop,
  output logic    empty
);

  logic [1:0] idx_r, idx_nxt;
  logic       last;

  // select the current token and step through the bundle
  always_comb begin
    out_item = head.toks[idx_r];
    empty    = q_empty;
    last     = (idx_r == 2'(head.cnt - 3'd1));
    q_pop    = pop && !q_empty && last;
    idx_nxt  = idx_r;
    if (pop && !q_empty) idx_nxt = last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

@@ rtl/c_token_scanner.sv @@
// ----------------------------------------------------------------------------
// c_token_scanner
// streaming tokenizer for c operators, punctuation and integer literals
// ----------------------------------------------------------------------------
// One source byte is taken per cycle on push while full is low; the front
// scans it in that same cycle and writes every token it finishes into a
// four-bundle queue. The back returns one token per cycle on pop, so a byte
// that closes several tokens (at most four) occupies the output for that many
// pops; the queue absorbs such bursts and full rises only once it holds four
// bundles. After an error token the scanner ignores bytes until end of input,
// and the end token leaves it at line 1, column 1 for the next file.
module c_token_scanner
  import cts_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output logic     empty,
  input  logic     pop,
  output tok_t     out_item
);

  logic    take, b_push, q_pop, q_empty;
  bundle_t b_data, q_head;

  assign take = push && !full;

  cts_front u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .item(in_item),
    .bundle_push(b_push), .bundle(b_data)
  );

  cts_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push_i(b_push), .wdata(b_data), .pop_i(q_pop),
    .head(q_head), .full(full), .empty(q_empty)
  );

  cts_back u_back (
    .clk(clk), .rst_n(rst_n), .head(q_head), .q_empty(q_empty), .q_pop(q_pop),
    .out_item(out_item), .pop(pop), .empty(empty)
  );

endmodule

@@ sim/tb_c_token_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_token_scanner
// drives source bytes through the scanner with bursty pushes and irregular
// pops, predicts every token from its own scanner model and compares each
// popped token field by field with the oldest predicted one
// ----------------------------------------------------------------------------
module tb_c_token_scanner;
  import cts_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  // token prediction and comparison
  class token_board;
    tok_t             pending[$];
    tok_t             run_toks[$];
    int               errors;
    int               noted;
    logic [15:0]      line_n, col_n, start_ln, start_col;
    logic [7:0]       win[3];
    int               fill;
    mode_t            mode;
    logic [1:0]       radix;
    logic [63:0]      acc;
    logic             ovf, halted;

    function new();
      errors = 0;
      noted  = 0;
      clear_state();
    endfunction

    function void clear_state();
      line_n = 1; col_n = 1; start_ln = 1; start_col = 1;
      win = '{8'h00, 8'h00, 8'h00};
      fill = 0; mode = MODE_IDLE; radix = RADIX_DEC;
      acc = '0; ovf = 1'b0; halted = 1'b0;
    endfunction

    function logic [15:0] sat_add(logic [15:0] p, int k);
      logic [16:0] s;
      s = {1'b0, p} + 17'(k);
      return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function void put(logic [2:0] cls, logic [5:0] code, logic [63:0] val, logic ov,
                      logic [15:0] ln, logic [15:0] col);
      tok_t t;
      t = '{cls, code, val, ov, ln, col, 1'b0};
      if (run_toks.size() < MAX_OUT) run_toks = {run_toks, t};
    endfunction

    function bit same_chars(sym_t e, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                            int n);
      return (n < 1 || e.c0 == b0) && (n < 2 || e.c1 == b1) && (n < 3 || e.c2 == b2);
    endfunction

    // exact symbol lookup, operators before punctuation
    function bit lookup(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, int n,
                        output logic [2:0] cls, output logic [5:0] code);
      cls = CLS_ERROR;
      code = ERR_BADCHAR;
      for (int i = 0; i < OP_COUNT; i++) begin
        if (OP_TAB[i].len == n && same_chars(OP_TAB[i], b0, b1, b2, n)) begin
          cls = CLS_OP; code = 6'(i); return 1'b1;
        end
      end
      for (int i = 0; i < PUNCT_COUNT; i++) begin
        if (PUNCT_TAB[i].len == n && same_chars(PUNCT_TAB[i], b0, b1, b2, n)) begin
          cls = CLS_PUNCT; code = 6'(i); return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function bit symbol_char(logic [7:0] c);
      logic [2:0] cls;
      logic [5:0] code;
      return lookup(c, 8'h00, 8'h00, 1, cls, code);
    endfunction

    function bit window_grows();
      for (int i = 0; i < OP_COUNT; i++)
        if (OP_TAB[i].len > fill && same_chars(OP_TAB[i], win[0], win[1], win[2], fill))
          return 1'b1;
      for (int i = 0; i < PUNCT_COUNT; i++)
        if (PUNCT_TAB[i].len > fill &&
            same_chars(PUNCT_TAB[i], win[0], win[1], win[2], fill))
          return 1'b1;
      return 1'b0;
    endfunction

    // longest match at the window head
    function void emit_head();
      int         len;
      logic [2:0] cls;
      logic [5:0] code;
      len = fill;
      while (len > 1 && !lookup(win[0], win[1], win[2], len, cls, code)) len--;
      if (!lookup(win[0], win[1], win[2], len, cls, code)) begin
        cls = CLS_ERROR; code = ERR_BADCHAR;
      end
      put(cls, code, '0, 1'b0, start_ln, start_col);
      for (int i = 0; i < 3; i++) win[i] = (i + len < fill) ? win[i + len] : 8'h00;
      fill -= len;
      start_col = sat_add(start_col, len);
    endfunction

    function void sym_add(logic [7:0] c, logic [15:0] ln, logic [15:0] col);
      if (fill == 0) begin
        start_ln = ln; start_col = col;
      end
      if (fill < 3) begin
        win[fill] = c; fill++;
      end
      while (fill > 0 && !window_grows()) emit_head();
      mode = (fill != 0) ? MODE_SYMBOL : MODE_IDLE;
    endfunction

    function void sym_drain();
      while (fill > 0) emit_head();
      mode = MODE_IDLE;
    endfunction

    function int digit_val(logic [7:0] c, logic [1:0] rdx);
      int d;
      d = -1;
      if (c >= "0" && c <= "9") d = c - "0";
      else if (c >= "a" && c <= "f") d = c - "a" + 10;
      else if (c >= "A" && c <= "F") d = c - "A" + 10;
      if (rdx == RADIX_DEC && d > 9) d = -1;
      if (rdx == RADIX_BIN && d > 1) d = -1;
      return d;
    endfunction

    // saturating value accumulation
    function void add_digit(int d);
      logic [63:0] base;
      base = (radix == RADIX_HEX) ? 64'd16 : ((radix == RADIX_BIN) ? 64'd2 : 64'd10);
      if (ovf) return;
      if (acc > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / base) begin
        acc = 64'hFFFF_FFFF_FFFF_FFFF; ovf = 1'b1;
      end else begin
        acc = acc * base + 64'(d);
      end
    endfunction

    function void emit_literal();
      put(CLS_LITERAL, 6'(radix), acc, ovf, start_ln, start_col);
      mode = MODE_IDLE;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C ||
             c == 8'h0D;
    endfunction

    function void start_token(logic [7:0] c, logic [15:0] ln, logic [15:0] col);
      if (is_blank(c)) return;
      if (c >= "0" && c <= "9") begin
        start_ln = ln; start_col = col; radix = RADIX_DEC; ovf = 1'b0;
        acc = 64'(c - "0");
        mode = (c == "0") ? MODE_ZERO : MODE_DEC;
        return;
      end
      if (symbol_char(c)) begin
        sym_add(c, ln, col);
        return;
      end
      put(CLS_ERROR, ERR_BADCHAR, '0, 1'b0, ln, col);
      halted = 1'b1;
    endfunction

    function void scan_byte(logic [7:0] c, logic [15:0] ln, logic [15:0] col);
      int d;
      case (mode)
        MODE_ZERO: begin
          if (c == "x" || c == "X") begin
            radix = RADIX_HEX; mode = MODE_PREFIX; return;
          end
          if (c == "b" || c == "B") begin
            radix = RADIX_BIN; mode = MODE_PREFIX; return;
          end
          if (c >= "0" && c <= "9") begin
            add_digit(c - "0"); mode = MODE_DEC; return;
          end
          emit_literal();
        end
        MODE_PREFIX: begin
          d = digit_val(c, radix);
          if (d >= 0) begin
            add_digit(d); mode = MODE_DIGITS; return;
          end
          put(CLS_ERROR, ERR_PREFIX, '0, 1'b0, start_ln, start_col);
          mode = MODE_IDLE;
          halted = 1'b1;
          return;
        end
        MODE_DEC, MODE_DIGITS: begin
          d = digit_val(c, radix);
          if (d >= 0) begin
            add_digit(d); return;
          end
          emit_literal();
        end
        MODE_SYMBOL: begin
          if (symbol_char(c)) begin
            sym_add(c, line_n, col_n); return;
          end
          sym_drain();
        end
        default: mode = MODE_IDLE;
      endcase
      start_token(c, ln, col);
    endfunction

    // predict the tokens of one accepted item
    function void note(in_item_t it);
      run_toks.delete();
      noted++;
      if (it.end_of_input) begin
        if (!halted) begin
          if (mode == MODE_ZERO || mode == MODE_DEC || mode == MODE_DIGITS) emit_literal();
          else if (mode == MODE_PREFIX) put(CLS_ERROR, ERR_PREFIX, '0, 1'b0, start_ln,
                                            start_col);
          else if (mode == MODE_SYMBOL) sym_drain();
        end
        put(CLS_EOF, 6'd0, '0, 1'b0, line_n, col_n);
        clear_state();
      end else begin
        if (!halted) scan_byte(it.byte_in, line_n, col_n);
        if (it.byte_in == 8'h0A) begin
          line_n = sat_add(line_n, 1); col_n = 1;
        end else begin
          col_n = sat_add(col_n, 1);
        end
      end
      if (run_toks.size() > 0) run_toks[run_toks.size() - 1].last_of_run = 1'b1;
      pending = {pending, run_toks};
    endfunction

    function void check(tok_t got);
      tok_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected token %p", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got.token_class != want.token_class)
        report("token_class", want.token_class, got.token_class);
      if (got.token_code != want.token_code)
        report("token_code", want.token_code, got.token_code);
      if (got.literal_value != want.literal_value)
        report("literal_value", want.literal_value, got.literal_value);
      if (got.literal_overflow != want.literal_overflow)
        report("literal_overflow", want.literal_overflow, got.literal_overflow);
      if (got.token_line != want.token_line)
        report("token_line", want.token_line, got.token_line);
      if (got.token_column != want.token_column)
        report("token_column", want.token_column, got.token_column);
      if (got.last_of_run != want.last_of_run)
        report("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

    function void report(string fld, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, fld, want, got);
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     push;
  logic     full;
  in_item_t in_item;
  logic     empty;
  logic     pop;
  tok_t     out_item;

  token_board board;
  int         burst_left;
  bit         held_off;
  int         idle_cycles;

  c_token_scanner u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // offer one item until it is taken, with bursts and gaps around it
  task automatic send_item(logic [7:0] b, logic eoi);
    logic f;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push    <= 1'b1;
    in_item <= '{b, eoi};
    forever begin
      @(negedge clk);
      f = full;
      @(posedge clk);
      if (!f) break;
    end
    board.note('{b, eoi});
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eof();
    send_item(8'($urandom), 1'b1);
  endtask

  // random digits of a radix, sometimes long enough to overflow
  task automatic send_literal();
    int    kind;
    int    n;
    string digs;
    kind = $urandom_range(0, 2);
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 70) : $urandom_range(1, 5);
    if (kind == 0) begin
      digs = "0123456789";
    end else if (kind == 1) begin
      send_text($urandom_range(0, 1) ? "0x" : "0X");
      digs = "0123456789abcdefABCDEF";
    end else begin
      send_text($urandom_range(0, 1) ? "0b" : "0B");
      digs = "01";
    end
    for (int i = 0; i < n; i++) send_item(digs[$urandom_range(0, digs.len() - 1)], 1'b0);
  endtask

  task automatic send_symbols();
    string syms;
    syms = "<>*&+-/%=!|^~?{}[](),;:.";
    repeat ($urandom_range(1, 4)) send_item(syms[$urandom_range(0, syms.len() - 1)], 1'b0);
  endtask

  // receiver: irregular stalls plus one long hold-off
  initial begin
    logic e, p;
    tok_t o;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      e = empty;
      p = pop;
      o = out_item;
      @(posedge clk);
      if (p && !e) board.check(o);
      if (held_off) pop <= 1'b0;
      else if (board.noted % 200 < 60) pop <= 1'b1;
      else pop <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    held_off = 1'b0;
    wait (board != null && board.noted >= 150);
    held_off = 1'b1;
    repeat (400) @(posedge clk);
    held_off = 1'b0;
  end

  // watchdog on cycles with no handshake
  initial begin
    idle_cycles = 0;
    forever begin
      @(negedge clk);
      if ((push && !full) || (pop && !empty) || !rst_n) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("c_token_scanner verification failed");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    board      = new();
    burst_left = 0;
    rst_n      = 1'b0;
    push       = 1'b0;
    in_item    = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: literal extremes, window corners, fallbacks, errors
    send_text("0 0xFFFFFFFFFFFFFFFF 18446744073709551616 0b101\n");
    send_text("<<=>>=...->::-> - >..+\t\v\f\r");
    send_eof();
    send_text("12ab 7");
    send_eof();
    send_text("0x");
    send_eof();
    send_text("0bz");
    send_eof();
    send_item(8'hFF, 1'b0);
    send_eof();

    // random token streams with occasional noise and broken sequences
    while (board.noted < 490) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5:       send_literal();
        6, 7, 8, 9, 10, 11, 12: send_symbols();
        13:                     send_item(8'($urandom), 1'b0);
        14:                     send_text("0x ");
        15:                     send_eof();
        default:                send_item($urandom_range(0, 1) ? " " : "\n", 1'b0);
      endcase
      if ($urandom_range(0, 1)) send_item(" ", 1'b0);
      if ($urandom_range(0, 30) == 0) send_eof();
    end
    send_eof();

    push <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("c_token_scanner verification clean");
    end else begin
      $display("c_token_scanner verification failed");
    end
    $finish;
  end

endmodule
